// ----- rtl/core/tdp_pkg.sv -----
// time-of-day text parser: shared types, widths and character codes
// used by all modules of the parser core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int ACC_W    = 7;
    localparam int M_DATA_W = 24;

    // range limits and noon
    localparam logic [ACC_W-1:0] HOUR_MAX   = 7'd23;
    localparam logic [ACC_W-1:0] MINSEC_MAX = 7'd59;
    localparam logic [ACC_W-1:0] NOON       = 7'd12;

    // separator after reset is a colon
    localparam logic [CHAR_W-1:0] SEP_RESET = 8'h3A;

    // character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LO_P  = 8'h70;
    localparam logic [CHAR_W-1:0] CH_UP_P  = 8'h50;

    // suffix kinds
    localparam logic [1:0] SUF_NONE = 2'd0;
    localparam logic [1:0] SUF_AM   = 2'd1;
    localparam logic [1:0] SUF_PM   = 2'd2;

    // field selectors
    localparam logic [1:0] FLD_HOUR = 2'd0;
    localparam logic [1:0] FLD_MIN  = 2'd1;
    localparam logic [1:0] FLD_SEC  = 2'd2;

    // one parsed time
    typedef struct packed {
        logic              valid_res;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } tdp_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/tdp_parse.sv -----
// time-of-day text parser: per-string parse state and the per-character update
// with the end-of-string range check; depends on tdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdp_parse (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        step,
    input  wire [tdp_pkg::CHAR_W-1:0]  char_code,
    input  wire                        is_last,
    input  wire [tdp_pkg::CHAR_W-1:0]  sep_char,
    output tdp_pkg::tdp_res_t          res
);
    import tdp_pkg::*;

    logic [1:0]       field_reg,  field_next;
    logic [1:0]       dcount_reg, dcount_next;
    logic [ACC_W-1:0] hour_reg,   hour_next;
    logic [ACC_W-1:0] min_reg,    min_next;
    logic [ACC_W-1:0] sec_reg,    sec_next;
    logic [1:0]       suf_reg,    suf_next;
    logic             err_reg,    err_next;
    logic             start_reg;

    logic             is_digit, is_am, is_pm, is_sep;
    logic [ACC_W-1:0] digit;
    logic [ACC_W-1:0] cur_acc, acc_upd;
    logic             ok;

    // character classes
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_am    = (char_code == CH_LO_A) || (char_code == CH_UP_A);
    assign is_pm    = (char_code == CH_LO_P) || (char_code == CH_UP_P);
    assign is_sep   = !is_digit && !is_am && !is_pm && (char_code == sep_char);
    assign digit    = ACC_W'(char_code - CH_ZERO);

    // accumulator of the current field times ten plus the digit
    always_comb begin
        case (field_reg)
            FLD_HOUR: cur_acc = hour_reg;
            FLD_MIN:  cur_acc = min_reg;
            default:  cur_acc = sec_reg;
        endcase
        acc_upd = ACC_W'({cur_acc, 3'b000} + {cur_acc, 1'b0} + {3'b000, digit});
    end

    // next parse state for this character
    always_comb begin
        field_next  = field_reg;
        dcount_next = dcount_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        suf_next    = suf_reg;
        err_next    = err_reg;
        if (is_digit) begin
            if (dcount_reg >= 2'd2) begin
                err_next = 1'b1;
            end else begin
                case (field_reg)
                    FLD_HOUR: hour_next = acc_upd;
                    FLD_MIN:  min_next  = acc_upd;
                    default:  sec_next  = acc_upd;
                endcase
            end
            if (dcount_reg != 2'd3) begin
                dcount_next = dcount_reg + 2'd1;
            end
        end else if (is_am || is_pm) begin
            if (!is_last || start_reg || dcount_reg == 2'd0) begin
                err_next = 1'b1;
            end else begin
                suf_next = is_am ? SUF_AM : SUF_PM;
            end
        end else if (is_sep) begin
            if (start_reg || dcount_reg == 2'd0 || field_reg >= FLD_SEC) begin
                err_next = 1'b1;
            end else begin
                field_next  = field_reg + 2'd1;
                dcount_next = 2'd0;
            end
        end else begin
            err_next = 1'b1;
        end
    end

    // range check and 12-hour conversion on the finished string
    always_comb begin
        ok = !err_next && dcount_next != 2'd0 && dcount_next != 2'd3
             && hour_next <= HOUR_MAX && min_next <= MINSEC_MAX
             && sec_next <= MINSEC_MAX
             && !(suf_next != SUF_NONE && hour_next > NOON);
        res = '0;
        if (ok) begin
            res.valid_res = 1'b1;
            res.minute    = min_next[MIN_W-1:0];
            res.second    = sec_next[SEC_W-1:0];
            if (suf_next == SUF_AM && hour_next == NOON) begin
                res.hour = '0;
            end else if (suf_next == SUF_PM && hour_next < NOON) begin
                res.hour = HOUR_W'(hour_next + NOON);
            end else begin
                res.hour = hour_next[HOUR_W-1:0];
            end
        end
    end

    // state register, cleared after the last character of a string
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && is_last)) begin
            field_reg  <= FLD_HOUR;
            dcount_reg <= 2'd0;
            hour_reg   <= '0;
            min_reg    <= '0;
            sec_reg    <= '0;
            suf_reg    <= SUF_NONE;
            err_reg    <= 1'b0;
            start_reg  <= 1'b1;
        end else if (step) begin
            field_reg  <= field_next;
            dcount_reg <= dcount_next;
            hour_reg   <= hour_next;
            min_reg    <= min_next;
            sec_reg    <= sec_next;
            suf_reg    <= suf_next;
            err_reg    <= err_next;
            start_reg  <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tdp_out_reg.sv -----
// time-of-day text parser: result register holding one parsed time until taken
// depends on tdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdp_out_reg (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                load,
    input  wire tdp_pkg::tdp_res_t res_in,
    input  wire                m_tready,
    output logic               m_tvalid,
    output logic               free,
    output tdp_pkg::tdp_res_t  res_out
);
    import tdp_pkg::*;

    logic     valid_reg;
    tdp_res_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/time_of_day_text_parser_core.sv -----
// time-of-day text parser core: input word register, parser and result register
// depends on tdp_pkg, tdp_parse and tdp_out_reg
//
// usage:
//   s_tdata carries one character (ascii byte) per word, s_tlast marks the
//   final character of a time string (forms H, H:M, H:M:S, optional a/p suffix)
//   one result word follows each string: m_tuser is 1 for a legal time and
//   m_tdata holds hour, minute, second in 24-hour form (all zero when illegal)
//   cfg_data sets the field separator byte; cfg_ready is always high and the
//   separator should only change while no string is in flight
// timing:
//   a character is registered on acceptance and parsed the next cycle; the
//   parse state updates as each character leaves the input register and the
//   last character's result is loaded into the result register; one character
//   is taken every cycle while no final character waits for the result register
// reset:
//   aresetn low clears the parse state, both valid flags and sets the
//   separator back to a colon
// back pressure:
//   while a result waits, non-final characters keep flowing; a final character
//   waits in the input register until the result register frees up
`timescale 1ns / 1ps
`default_nettype none

module time_of_day_text_parser_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [tdp_pkg::CHAR_W-1:0]        cfg_data,      // separator_char
    // character input
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [tdp_pkg::CHAR_W-1:0]        s_tdata,       // [7:0] char_code
    input  wire                              s_tlast,       // is_last
    // parsed time output
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [tdp_pkg::M_DATA_W-1:0]     m_tdata,       // [4:0] hour, [10:5] minute,
                                                            // [16:11] second, [23:17] zero
    output logic                             m_tuser        // valid_res
);
    import tdp_pkg::*;

    logic [CHAR_W-1:0] sep_reg;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              out_free;
    logic              advance;
    tdp_res_t          parse_res;
    tdp_res_t          out_res;

    // separator register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg <= SEP_RESET;
        end else if (cfg_valid) begin
            sep_reg <= cfg_data;
        end
    end

    // a registered word moves on unless it ends a string and the result is blocked
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tdp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .char_code (in_char_reg),
        .is_last   (in_last_reg),
        .sep_char  (sep_reg),
        .res       (parse_res)
    );

    tdp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && in_last_reg),
        .res_in   (parse_res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .free     (out_free),
        .res_out  (out_res)
    );

    // output word packing
    assign m_tuser = out_res.valid_res;
    assign m_tdata = {(M_DATA_W - HOUR_W - MIN_W - SEC_W)'(0),
                      out_res.second, out_res.minute, out_res.hour};

endmodule

`default_nettype wire

// ----- rtl/core/tdp_checker.sv -----
// time-of-day text parser: port-level checker and its bind to the core
// depends on tdp_pkg and time_of_day_text_parser_core
`timescale 1ns / 1ps
`default_nettype none

module tdp_checker (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    input  wire [tdp_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire                              m_tuser
);
    import tdp_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // illegal string gives all-zero time
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("illegal string with nonzero time");

    // legal time is in range and padding is zero
    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[4:0] <= 5'd23 && m_tdata[10:5] <= 6'd59
                               && m_tdata[16:11] <= 6'd59 && m_tdata[23:17] == 7'd0)
        else $error("legal time out of range");

endmodule

bind time_of_day_text_parser_core tdp_checker u_tdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
